[hw/rtl/mcg_pkg.sv]
`default_nettype none
package mcg_pkg;

	localparam int unsigned CoordWidth = 15;
	localparam int unsigned RadiusWidth = 6;
	localparam int unsigned OffsetWidth = 6;
	localparam int unsigned PointWidth = 16;
	localparam int unsigned MaxRadius = 63;
	localparam int unsigned MaxResults = 46;
	localparam int unsigned CountWidth = $clog2(MaxResults);

	localparam int unsigned InDataWidth = 40;
	localparam int unsigned OutDataWidth = 144;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} mcg_state_t;

	// controller to datapath
	typedef struct packed {
		logic start;   // load a new circle request
		logic advance; // register one step into the output and move the recurrence on
	} mcg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;    // the step at hand is the final one of this circle
	} mcg_status_t;

endpackage
`default_nettype wire

[hw/rtl/midpoint_circle_generator.sv]
`default_nettype none
// Midpoint circle generator: one circle request in, one result per octant step out.
// Input channel s_axis_*: one transfer carries a signed centre and a radius (0..63).
// Output channel m_axis_*: one transfer per octant step, holding the major and minor
// offsets and the eight mirrored coordinates centre +- offset; tlast marks the final
// step of the circle. A zero radius gives a single step at the centre.
// A circle of radius r yields about r/sqrt(2) + 1 steps, at most 46.
// The request is first loaded into the recurrence registers; the first step is then
// registered into the output register. Throughput: one step per cycle while the
// receiver keeps tready high, set by the single-step recurrence unit in the datapath;
// the next request is taken only once the last step of a circle has been registered.
// s_axis_tready is high only while no circle is being stepped; the next request
// may be taken while the last step of the previous circle still waits at the output.
// When the receiver stalls, the output register holds its step and the recurrence
// freezes until the transfer completes.
// Reset (arst_n low, asynchronous) returns to idle and drops m_axis_tvalid.
module midpoint_circle_generator
	import mcg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// [14:0] center_x, [29:15] center_y, [35:30] radius, [39:36] zero
	input  wire logic [InDataWidth-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// [5:0] offset_major, [11:6] offset_minor, [27:12] x_plus_major,
	// [43:28] x_minus_major, [59:44] x_plus_minor, [75:60] x_minus_minor,
	// [91:76] y_plus_major, [107:92] y_minus_major, [123:108] y_plus_minor,
	// [139:124] y_minus_minor, [143:140] zero
	output logic [OutDataWidth-1:0]      m_axis_tdata,
	output logic                         m_axis_tlast
);

	mcg_cmd_t    cmd;
	mcg_status_t status;
	logic        busy;

	// sequencing: accept requests, pace steps against the output register
	mcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (m_axis_tvalid)
	);

	// recurrence registers, step counter and the output register
	mcg_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.status   (status),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

	// take a new request only between circles
	assign s_axis_tready = !busy;

	// an emitted step never has the minor offset past the major one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[11:6] <= m_axis_tdata[5:0]))
		else $error("minor offset exceeds major offset");

	// a step that is not the last one means the circle is still being stepped
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> busy)
		else $error("non-final step shown while idle");

	// an idle block cannot be stepping
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.advance)
		else $error("step advanced while idle");

endmodule
`default_nettype wire

[hw/rtl/mcg_ctrl.sv]
`default_nettype none
module mcg_ctrl
	import mcg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_ready,
	input  wire mcg_status_t status,
	output mcg_cmd_t         cmd,
	output logic             busy,
	output logic             out_valid
);

	mcg_state_t state_q;
	mcg_state_t state_next;
	logic       out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_RUN;
				end
			end
			S_RUN: begin
				if (cmd.advance && status.last) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.start   = 1'b0;
		cmd.advance = 1'b0;
		busy        = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.start = in_valid;
			end
			S_RUN: begin
				busy        = 1'b1;
				// step only into a free or draining output register
				cmd.advance = !out_valid_q || out_ready;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[hw/rtl/mcg_datapath.sv]
`default_nettype none
module mcg_datapath
	import mcg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mcg_cmd_t                cmd,
	input  wire logic [InDataWidth-1:0]  in_data,
	output mcg_status_t                  status,
	output logic [OutDataWidth-1:0]      out_data,
	output logic                         out_last
);

	logic signed [7:0]             dx_q;
	logic        [6:0]             dy_q;
	logic signed [9:0]             acc_q;
	logic        [CoordWidth-1:0]  cx_q;
	logic        [CoordWidth-1:0]  cy_q;
	logic        [CountWidth-1:0]  cnt_q;

	logic [RadiusWidth-1:0] radius;
	logic [6:0]             radius_sat;
	logic [6:0]             ndy;
	logic signed [7:0]      dx_dec;
	logic signed [7:0]      ndx;
	logic signed [9:0]      acc_sub;
	logic signed [9:0]      nacc;
	logic                   last;

	logic [PointWidth-1:0] cx_ext, cy_ext, major_ext, minor_ext;

	logic [OffsetWidth-1:0] major_q, minor_q;
	logic [PointWidth-1:0]  xpj_q, xmj_q, xpn_q, xmn_q, ypj_q, ymj_q, ypn_q, ymn_q;
	logic                   last_q;

	assign radius     = in_data[2*CoordWidth +: RadiusWidth];
	assign radius_sat = ({1'b0, radius} > 7'(MaxRadius)) ? 7'(MaxRadius) : {1'b0, radius};

	// one midpoint step: minor up, error down by 2*minor+1, pull major in on underflow
	assign ndy     = dy_q + 7'd1;
	assign acc_sub = acc_q - $signed({2'b00, dy_q, 1'b0}) - 10'sd1;
	assign dx_dec  = dx_q - 8'sd1;
	assign ndx     = acc_sub[9] ? dx_dec : dx_q;
	assign nacc    = acc_sub[9] ? (acc_sub + $signed({dx_dec[7], dx_dec, 1'b0})) : acc_sub;
	assign last    = ($signed({1'b0, ndy}) > ndx) || (cnt_q == CountWidth'(MaxResults - 1));

	assign status.last = last;

	assign cx_ext    = {cx_q[CoordWidth-1], cx_q};
	assign cy_ext    = {cy_q[CoordWidth-1], cy_q};
	assign major_ext = {{(PointWidth-OffsetWidth){1'b0}}, dx_q[OffsetWidth-1:0]};
	assign minor_ext = {{(PointWidth-OffsetWidth){1'b0}}, dy_q[OffsetWidth-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q  <= '0;
			dy_q  <= '0;
			acc_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			dx_q  <= $signed({1'b0, radius_sat});
			dy_q  <= '0;
			acc_q <= $signed({3'b000, radius_sat}) - 10'sd1;
			cx_q  <= in_data[0 +: CoordWidth];
			cy_q  <= in_data[CoordWidth +: CoordWidth];
			cnt_q <= '0;
		end else if (cmd.advance) begin
			dx_q  <= ndx;
			dy_q  <= ndy;
			acc_q <= nacc;
			cnt_q <= cnt_q + CountWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			major_q <= dx_q[OffsetWidth-1:0];
			minor_q <= dy_q[OffsetWidth-1:0];
			xpj_q   <= cx_ext + major_ext;
			xmj_q   <= cx_ext - major_ext;
			xpn_q   <= cx_ext + minor_ext;
			xmn_q   <= cx_ext - minor_ext;
			ypj_q   <= cy_ext + major_ext;
			ymj_q   <= cy_ext - major_ext;
			ypn_q   <= cy_ext + minor_ext;
			ymn_q   <= cy_ext - minor_ext;
			last_q  <= last;
		end
	end

	assign out_data = {4'b0000, ymn_q, ypn_q, ymj_q, ypj_q, xmn_q, xpn_q, xmj_q, xpj_q,
		minor_q, major_q};
	assign out_last = last_q;

endmodule
`default_nettype wire
